[rtl/mrkh_pkg.sv]
// shared constants, types and helper functions for the multiply-rotate key hash
package mrkh_pkg;

  // word mixing constants
  localparam logic [63:0] MIX_C1     = 64'h87c3_7b91_1142_53d5;
  localparam logic [63:0] MIX_C2     = 64'h4cf5_ad43_2745_937f;
  localparam logic [63:0] STEP_ADD   = 64'h0000_0000_52dc_e729;

  // side constants, the black one is the short 15-digit value
  localparam logic [63:0] SIDE_WHITE = 64'ha5a5_a5a5_a5a5_a5a5;
  localparam logic [63:0] SIDE_BLACK = 64'h05a5_a5a5_a5a5_a5a5;

  // finalizer constants
  localparam logic [63:0] FIN_M1     = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] FIN_M2     = 64'hc4ce_b9fe_1a85_ec53;

  // seed after reset
  localparam logic [63:0] SEED_RESET = 64'd0;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_K1,
    S_K2,
    S_F1,
    S_F2,
    S_DONE
  } mrkh_state_t;

  // request to the shared multiplier
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  // status from the shared multiplier
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

  // rotate left by 31
  function automatic logic [63:0] rotl31(input logic [63:0] x);
    return {x[32:0], x[63:33]};
  endfunction

  // rotate left by 27
  function automatic logic [63:0] rotl27(input logic [63:0] x);
    return {x[36:0], x[63:37]};
  endfunction

  // xor with itself shifted right by 33
  function automatic logic [63:0] xsh33(input logic [63:0] x);
    return x ^ {33'd0, x[63:33]};
  endfunction

endpackage

[rtl/mrkh_ifs.sv]
// valid/ready channel interfaces for key words, hash results and seed writes

// one key word per request
interface mrkh_key_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_word;
  logic        white_turn;
  logic        last_word;

  modport source (output valid, output key_word, output white_turn, output last_word,
                  input ready);
  modport sink   (input valid, input key_word, input white_turn, input last_word,
                  output ready);
endinterface

// one finalized hash per request
interface mrkh_hash_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

// seed register write
interface mrkh_seed_if;
  logic        valid;
  logic        ready;
  logic [63:0] seed;

  modport source (output valid, output seed, input ready);
  modport sink   (input valid, input seed, output ready);
endinterface

[rtl/mrkh_mul.sv]
// iterative 64x64 low-half multiplier built on one shared 32x32 multiplier
module mrkh_mul
  import mrkh_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [63:0] a;
  logic [63:0] b;
  logic [1:0]  step;
  logic        busy;
  logic        done;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [31:0] mx;
  logic [31:0] my;

  // operand select for the shared multiplier
  always_comb begin
    case (step)
      2'd0: begin
        mx = a[31:0];
        my = b[31:0];
      end
      2'd1: begin
        mx = a[31:0];
        my = b[63:32];
      end
      2'd2: begin
        mx = a[63:32];
        my = b[31:0];
      end
      default: begin
        mx = 32'd0;
        my = 32'd0;
      end
    endcase
  end

  // control: busy, step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: registered partial product, then accumulate
  always_ff @(posedge clk) begin
    if (req.start) begin
      a <= req.a;
      b <= req.b;
    end else if (busy) begin
      prod <= {32'd0, mx} * {32'd0, my};
      case (step)
        2'd0:    acc <= acc;
        2'd1:    acc <= prod;
        default: acc <= acc + {prod[31:0], 32'd0};
      endcase
    end
  end

  assign rsp.busy    = busy;
  assign rsp.done    = done;
  assign rsp.product = acc;

endmodule

[rtl/multiply_rotate_key_hash64.sv]
// top level of the multiply-rotate 64-bit key hash with fmix64 finalizer
//
// Hashes a key given as a run of 64-bit words on the key channel, the last one marked by
// last_word. Each word goes through two 64-bit products on a shared iterative multiplier
// (one 32x32 partial product per cycle). The last word adds the two fmix64 products and a
// handoff to the output register. key.ready is high only while the block is idle. A
// finished hash waits in an output register, and the next key word is taken meanwhile.
// The seed is written through the cfg channel, which is always ready; write it only while
// no key is in flight. After a result, the running hash starts again from zero.
module multiply_rotate_key_hash64
  import mrkh_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  mrkh_key_if.sink      key,
  mrkh_hash_if.source   hash,
  mrkh_seed_if.sink     cfg
);

  mrkh_state_t state;
  mrkh_state_t state_next;
  mul_req_t    mul_req;
  mul_rsp_t    mul_rsp;

  logic [63:0] seed;
  logic [63:0] h;
  logic [63:0] h_next;
  logic [63:0] res;
  logic [63:0] res_next;
  logic        last_r;
  logic        white_r;
  logic        out_valid;
  logic [63:0] out_value;
  logic        out_load;
  logic [63:0] mixed;
  logic [63:0] rot;
  logic        key_acc;

  assign key.ready = (state == S_IDLE);
  assign key_acc   = key.valid && key.ready;
  assign cfg.ready = 1'b1;

  // shared multiplier
  mrkh_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // running hash update: rotl27(h ^ k) * 5 + add
  assign rot   = rotl27(h ^ mul_rsp.product);
  assign mixed = {rot[61:0], 2'b00} + rot + STEP_ADD;

  // sequencer: next state, multiplier requests, hash updates
  always_comb begin
    state_next  = state;
    h_next      = h;
    res_next    = res;
    out_load    = 1'b0;
    mul_req     = '0;
    case (state)
      S_IDLE: begin
        if (key_acc) begin
          mul_req.start = 1'b1;
          mul_req.a     = key.key_word;
          mul_req.b     = MIX_C1;
          state_next    = S_K1;
        end
      end
      S_K1: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = rotl31(mul_rsp.product);
          mul_req.b     = MIX_C2;
          state_next    = S_K2;
        end
      end
      S_K2: begin
        if (mul_rsp.done) begin
          if (last_r) begin
            mul_req.start = 1'b1;
            mul_req.a     = xsh33(mixed ^ (white_r ? SIDE_WHITE : SIDE_BLACK) ^ seed);
            mul_req.b     = FIN_M1;
            h_next        = 64'd0;
            state_next    = S_F1;
          end else begin
            h_next     = mixed;
            state_next = S_IDLE;
          end
        end
      end
      S_F1: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = xsh33(mul_rsp.product);
          mul_req.b     = FIN_M2;
          state_next    = S_F2;
        end
      end
      S_F2: begin
        if (mul_rsp.done) begin
          res_next   = xsh33(mul_rsp.product);
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || hash.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and running hash registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      h     <= 64'd0;
    end else begin
      state <= state_next;
      h     <= h_next;
    end
  end

  // per-word flags and finalized value
  always_ff @(posedge clk) begin
    res <= res_next;
    if (key_acc) begin
      last_r  <= key.last_word;
      white_r <= key.white_turn;
    end
  end

  // seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (cfg.valid && cfg.ready) begin
      seed <= cfg.seed;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (hash.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= res;
    end
  end

  assign hash.valid      = out_valid;
  assign hash.hash_value = out_value;

  // multiplier results arrive only while a product is awaited
  a_done_in_mul_state: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> (state == S_K1 || state == S_K2 || state == S_F1 || state == S_F2))
    else $error("multiplier done outside a multiply state");

  // the block is ready only when the multiplier is free
  a_ready_mul_idle: assert property (@(posedge clk) disable iff (rst)
    key.ready |-> !mul_rsp.busy)
    else $error("key ready while multiplier busy");

  // an accepted word starts the multiplier
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    key_acc |=> (state == S_K1 && mul_rsp.busy))
    else $error("accepted word did not start mixing");

  // running hash is cleared while a key is being finalized
  a_hash_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_F1 || state == S_F2 || state == S_DONE) |-> (h == 64'd0))
    else $error("running hash not cleared after last word");

endmodule
